>>> hw/rtl/sirad_pkg.sv
`timescale 1ns / 1ps

package sirad_pkg;

  // Parameter defaults
  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int VALUE_BITS_DEF  = 32;

  // Symbol table register file
  localparam int NUM_REGS     = 8;
  localparam int REG_BITS     = 64;
  localparam int CFG_IDX_BITS = 4;
  localparam int REG_SEL_BITS = 3;
  localparam int CHAR_BITS    = 8;
  localparam int REG_BYTES    = REG_BITS / CHAR_BITS;
  localparam int TBL_IDX_BITS = 6;   // byte position in the full table
  localparam int RADIX_BITS   = 7;   // holds a radix of up to 64

  // Character codes
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_LOW   = 8'd32;   // space and below are illegal
  localparam logic [CHAR_BITS-1:0] CH_HIGH  = 8'd126;

  // Table checker status toward the sequencer
  typedef struct packed {
    logic                  busy;
    logic                  ok;
    logic [RADIX_BITS-1:0] radix;
  } tbl_status_t;

  // Sequencer commands to the digit unit
  typedef struct packed {
    logic load;
    logic step;
  } conv_ctrl_t;

endpackage

>>> hw/rtl/sirad_in_if.sv
`timescale 1ns / 1ps

interface sirad_in_if #(
  parameter int VALUE_BITS = sirad_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> hw/rtl/sirad_out_if.sv
`timescale 1ns / 1ps

interface sirad_out_if;
  logic                               valid;
  logic                               ready;
  logic [sirad_pkg::CHAR_BITS-1:0]    out_char;
  logic                               last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> hw/rtl/sirad_cfg.sv
`timescale 1ns / 1ps

module sirad_cfg #(
  parameter int MAX_SYMBOLS = sirad_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sirad_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sirad_pkg::REG_BITS-1:0]       cfg_wdata_i,
  input  logic [sirad_pkg::TBL_IDX_BITS-1:0]   lookup_idx_i,
  output logic [sirad_pkg::CHAR_BITS-1:0]      sym_o,
  output sirad_pkg::tbl_status_t               status_o
);

  localparam int CW   = $clog2(MAX_SYMBOLS + 1);   // scan index, reaches MAX_SYMBOLS
  localparam int TIW  = sirad_pkg::TBL_IDX_BITS;
  localparam int RSW  = sirad_pkg::REG_SEL_BITS;
  localparam int BSW  = TIW - RSW;
  localparam int CHW  = sirad_pkg::CHAR_BITS;
  localparam int RBW  = sirad_pkg::RADIX_BITS;
  localparam int NCH  = 2 ** CHW;
  localparam int CIW  = sirad_pkg::CFG_IDX_BITS;

  typedef enum logic {
    SC_IDLE,
    SC_SCAN
  } scan_e;

  scan_e state_q, state_d;
  logic [sirad_pkg::NUM_REGS-1:0][sirad_pkg::REG_BYTES-1:0][CHW-1:0] regs_q;
  logic [NCH-1:0] seen_q, seen_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           ok_q, ok_d;
  logic [RBW-1:0] radix_q, radix_d;
  logic           wr_hit;
  logic [TIW-1:0] sel;
  logic [RSW-1:0] rsel;
  logic [BSW-1:0] bsel;
  logic [CHW-1:0] sym;
  logic           legal;

  // Writes beyond the register list are dropped
  assign wr_hit = cfg_we_i && (cfg_idx_i < CIW'(sirad_pkg::NUM_REGS));

  // Single byte lookup port, owned by the scan while it runs
  assign sel   = (state_q == SC_SCAN) ? TIW'(idx_q) : lookup_idx_i;
  assign rsel  = sel[TIW-1:BSW];
  assign bsel  = sel[BSW-1:0];
  assign sym   = regs_q[rsel][bsel];
  assign sym_o = sym;

  assign legal = (sym > sirad_pkg::CH_LOW) && (sym <= sirad_pkg::CH_HIGH) &&
                 (sym != sirad_pkg::CH_PLUS) && (sym != sirad_pkg::CH_MINUS);

  // Table check: one symbol per cycle, duplicates caught by a seen map
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    seen_d  = seen_q;
    ok_d    = ok_q;
    radix_d = radix_q;
    if (wr_hit) begin
      state_d = SC_SCAN;
      idx_d   = '0;
      seen_d  = '0;
      ok_d    = 1'b0;
      radix_d = '0;
    end else if (state_q == SC_SCAN) begin
      if ((idx_q == CW'(MAX_SYMBOLS)) || (sym == '0)) begin
        state_d = SC_IDLE;
        ok_d    = (idx_q >= CW'(2));
        radix_d = RBW'(idx_q);
      end else if (!legal || seen_q[sym]) begin
        state_d = SC_IDLE;
        ok_d    = 1'b0;
      end else begin
        seen_d[sym] = 1'b1;
        idx_d       = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      regs_q  <= '0;
      seen_q  <= '0;
      idx_q   <= '0;
      ok_q    <= 1'b0;
      radix_q <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      idx_q   <= idx_d;
      ok_q    <= ok_d;
      radix_q <= radix_d;
      if (wr_hit) begin
        regs_q[cfg_idx_i[RSW-1:0]] <= cfg_wdata_i;
      end
    end
  end

  assign status_o.busy  = (state_q == SC_SCAN);
  assign status_o.ok    = ok_q;
  assign status_o.radix = radix_q;

endmodule

>>> hw/rtl/sirad_conv.sv
`timescale 1ns / 1ps

module sirad_conv #(
  parameter int VALUE_BITS  = sirad_pkg::VALUE_BITS_DEF,
  parameter int MAX_SYMBOLS = sirad_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sirad_pkg::conv_ctrl_t               ctrl_i,
  input  logic [VALUE_BITS-1:0]               mag_i,
  input  logic [sirad_pkg::RADIX_BITS-1:0]    radix_i,
  input  logic [$clog2(VALUE_BITS)-1:0]       rd_idx_i,
  output logic [$clog2(MAX_SYMBOLS)-1:0]      digit_o,
  output logic [$clog2(VALUE_BITS+1)-1:0]     ndig_o
);

  localparam int NDIG = VALUE_BITS;            // radix 2 worst case
  localparam int DW   = $clog2(MAX_SYMBOLS);
  localparam int SUMW = DW + 1;
  localparam int NW   = $clog2(VALUE_BITS + 1);
  localparam int IW   = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]       mag_q;
  logic [NDIG-1:0][DW-1:0]     dig_q, dig_d;
  logic [NW-1:0]               ndig_q, ndig_d;
  logic [SUMW-1:0]             radix_q;
  logic [NDIG-1:0]             gen, prop, cin, cout;
  logic [NDIG:0]               csum;
  logic [IW-1:0]               top_idx;
  logic [SUMW-1:0]             nxt [NDIG];

  // Per digit: doubling overflows the radix alone, or only with a carry in
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      gen[i]  = ({dig_q[i], 1'b0} >= radix_q);
      prop[i] = ({dig_q[i], 1'b1} == radix_q);
    end
  end

  // Carry chain across all digits as one add; the next magnitude bit enters at digit 0
  assign csum = {1'b0, gen | prop} + {1'b0, gen} + (NDIG+1)'(mag_q[VALUE_BITS-1]);
  assign cin  = csum[NDIG-1:0] ^ (gen | prop) ^ gen;

  // Double, add carry, correct by one radix
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      cout[i]  = gen[i] | (prop[i] & cin[i]);
      nxt[i]   = {dig_q[i], cin[i]} - (cout[i] ? radix_q : '0);
      dig_d[i] = nxt[i][DW-1:0];
    end
  end

  // Digits above the count are zero, so only the top digit can grow it
  assign top_idx = IW'(ndig_q - NW'(1));
  assign ndig_d  = ndig_q + NW'(cout[top_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q <= NW'(1);
    end else if (ctrl_i.load) begin
      ndig_q <= NW'(1);
    end else if (ctrl_i.step) begin
      ndig_q <= ndig_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q   <= mag_i;
      dig_q   <= '0;
      radix_q <= SUMW'(radix_i);
    end else if (ctrl_i.step) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
      dig_q <= dig_d;
    end
  end

  assign digit_o = dig_q[rd_idx_i];
  assign ndig_o  = ndig_q;

endmodule

>>> hw/rtl/signed_int_to_radix_digits.sv
// Signed integer to text in a radix set by a configured symbol table.
// Order: for a negative value the minus sign goes out first, then the digits, most
//   significant first; output stalls hold the emission of the sign and the digits.
// A new value is taken only once the last digit has entered the output register. The
//   digit unit takes one magnitude bit per cycle.
// Invalid table: the value is accepted and gives no output.
// Reset: async, active low; table clears to zero (invalid); each register write starts
//   a table check during which no value is accepted.
`timescale 1ns / 1ps

module signed_int_to_radix_digits #(
  parameter int MAX_SYMBOLS = sirad_pkg::MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = sirad_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sirad_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [sirad_pkg::REG_BITS-1:0]      cfg_wdata_i,
  sirad_in_if.sink                            in_i,
  sirad_out_if.source                         out_o
);

  localparam int DW   = $clog2(MAX_SYMBOLS);
  localparam int NW   = $clog2(VALUE_BITS + 1);
  localparam int IW   = $clog2(VALUE_BITS);
  localparam int CNTW = $clog2(VALUE_BITS);
  localparam int TIW  = sirad_pkg::TBL_IDX_BITS;
  localparam int CHW  = sirad_pkg::CHAR_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e                  state_q;
  logic [CNTW-1:0]         cnt_q;
  logic                    neg_q;
  logic [IW-1:0]           emit_idx_q;
  logic                    out_valid_q;
  logic [CHW-1:0]          out_char_q;
  logic                    out_last_q;

  sirad_pkg::tbl_status_t  status;
  sirad_pkg::conv_ctrl_t   ctrl;
  logic [VALUE_BITS-1:0]   raw;
  logic [VALUE_BITS-1:0]   mag;
  logic                    accept;
  logic                    slot_free;
  logic                    out_load;
  logic [DW-1:0]           digit;
  logic [NW-1:0]           ndig;
  logic [CHW-1:0]          sym;

  // Symbol registers and table check
  sirad_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .lookup_idx_i (TIW'(digit)),
    .sym_o        (sym),
    .status_o     (status)
  );

  // Shared double-and-correct digit unit
  sirad_conv #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .mag_i    (mag),
    .radix_i  (status.radix),
    .rd_idx_i (emit_idx_q),
    .digit_o  (digit),
    .ndig_o   (ndig)
  );

  // Input side; the most negative value negates onto itself, which is its magnitude
  assign raw         = in_i.value;
  assign mag         = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign in_i.ready  = (state_q == ST_IDLE) && !status.busy;
  assign accept      = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;

  // A character enters the output register this cycle
  assign out_load    = slot_free &&
                       (((state_q == ST_SIGN) && neg_q) || (state_q == ST_DIGIT));

  assign ctrl.load   = accept && status.ok;
  assign ctrl.step   = (state_q == ST_CONV);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && status.ok) begin
            neg_q   <= raw[VALUE_BITS-1];
            cnt_q   <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(VALUE_BITS - 1)) begin
            state_q <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          // Sign goes out first; a digit always follows it
          if (!neg_q) begin
            emit_idx_q <= IW'(ndig - NW'(1));
            state_q    <= ST_DIGIT;
          end else if (slot_free) begin
            out_char_q  <= sirad_pkg::CH_MINUS;
            out_last_q  <= 1'b0;
            emit_idx_q  <= IW'(ndig - NW'(1));
            state_q     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          // Most significant digit first
          if (slot_free) begin
            out_char_q  <= sym;
            out_last_q  <= (emit_idx_q == '0);
            if (emit_idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              emit_idx_q <= emit_idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

`ifndef SYNTHESIS
  // Digit count stays within the digit row
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ndig != '0) && (ndig <= NW'(VALUE_BITS)))
    else $error("digit count out of range");

  // Emission never reads above the most significant digit
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (NW'(emit_idx_q) < ndig))
    else $error("emit index beyond digit count");

  // Leaving the conversion happens only after every magnitude bit went in
  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |-> ($past(state_q) == ST_SIGN) ||
                             ($past(cnt_q) == CNTW'(VALUE_BITS - 1)))
    else $error("conversion ended early");
`endif

endmodule
